@@ sv/acrf_pkg.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO package
// Shared widths, command/phase/failure codes and the word and control types.
// ----------------------------------------------------------------------------
package acrf_pkg;

    localparam int RING_DEPTH  = 4096;
    localparam int SAMPLE_BITS = 32;
    localparam int ADDR_W      = $clog2(RING_DEPTH);
    localparam int CAP_W       = 13;
    localparam int WORD_W      = 32;
    localparam int COUNT_W     = 48;
    localparam int SESSION_W   = 16;

    localparam logic [2:0] MODE_RESET   = 3'd0;
    localparam logic [2:0] MODE_PREPARE = 3'd1;
    localparam logic [2:0] MODE_CLEAR   = 3'd2;
    localparam logic [2:0] MODE_BEGIN   = 3'd3;
    localparam logic [2:0] MODE_CAPTURE = 3'd4;
    localparam logic [2:0] MODE_STOP    = 3'd5;
    localparam logic [2:0] MODE_DRAIN   = 3'd6;
    localparam logic [2:0] MODE_STATUS  = 3'd7;

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_PREPARED  = 3'd1;
    localparam logic [2:0] PH_CAPTURING = 3'd2;
    localparam logic [2:0] PH_COMPLETE  = 3'd3;
    localparam logic [2:0] PH_FAILED    = 3'd4;

    localparam logic [1:0] FAIL_NONE     = 2'd0;
    localparam logic [1:0] FAIL_MISSING  = 2'd1;
    localparam logic [1:0] FAIL_OVERFLOW = 2'd2;

    typedef struct packed {
        logic [2:0]           mode;
        logic                 layout_stereo;
        logic [SESSION_W-1:0] session_id;
        logic [COUNT_W-1:0]   start_frame;
        logic [1:0]           channels_present;
        logic [WORD_W-1:0]    left_sample;
        logic [WORD_W-1:0]    right_sample;
    } t_cmd;

    typedef struct packed {
        logic               done_ok;
        logic [2:0]         phase_now;
        logic [1:0]         failure_code;
        logic               frame_valid;
        logic [WORD_W-1:0]  left_out;
        logic [WORD_W-1:0]  right_out;
        logic [CAP_W-1:0]   fill_level;
        logic [COUNT_W-1:0] frames_accepted;
    } t_rsp;

    typedef struct packed {
        logic latch;
        logic exec;
        logic load;
    } t_ctrl_cmd;

endpackage

@@ sv/acrf_stream_if.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface acrf_cmd_if import acrf_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [2:0]           mode;
    logic                 layout_stereo;
    logic [SESSION_W-1:0] session_id;
    logic [COUNT_W-1:0]   start_frame;
    logic [1:0]           channels_present;
    logic [WORD_W-1:0]    left_sample;
    logic [WORD_W-1:0]    right_sample;

    modport source (
        output valid, mode, layout_stereo, session_id, start_frame,
               channels_present, left_sample, right_sample,
        input  ready
    );
    modport sink (
        input  valid, mode, layout_stereo, session_id, start_frame,
               channels_present, left_sample, right_sample,
        output ready
    );
endinterface

interface acrf_rsp_if import acrf_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               done_ok;
    logic [2:0]         phase_now;
    logic [1:0]         failure_code;
    logic               frame_valid;
    logic [WORD_W-1:0]  left_out;
    logic [WORD_W-1:0]  right_out;
    logic [CAP_W-1:0]   fill_level;
    logic [COUNT_W-1:0] frames_accepted;

    modport source (
        output valid, done_ok, phase_now, failure_code, frame_valid,
               left_out, right_out, fill_level, frames_accepted,
        input  ready
    );
    modport sink (
        input  valid, done_ok, phase_now, failure_code, frame_valid,
               left_out, right_out, fill_level, frames_accepted,
        output ready
    );
endinterface

@@ sv/audio_capture_ring_fifo.sv @@
// Each command word is latched on acceptance, executed once the result slot is
// free, then loaded as a result word; the next command word may be accepted in
// the load step. Execute and the registered ring read port set the pace.
// Reset: synchronous, active low; phase idle, pointers and counts zero, capacity
// 4096; ring contents are not cleared and no clearing pass is run.
// ----------------------------------------------------------------------------
// Audio capture ring FIFO
// Mono/stereo sample capture ring with a recording lifecycle, one result
// word per command word.
// ----------------------------------------------------------------------------
module audio_capture_ring_fifo import acrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    acrf_cmd_if.sink         i_cmd,
    acrf_rsp_if.source       o_rsp
);

    t_ctrl_cmd ctrl_cmd;
    t_cmd      cmd_word;
    t_rsp      rsp_word;

    assign cmd_word.mode             = i_cmd.mode;
    assign cmd_word.layout_stereo    = i_cmd.layout_stereo;
    assign cmd_word.session_id       = i_cmd.session_id;
    assign cmd_word.start_frame      = i_cmd.start_frame;
    assign cmd_word.channels_present = i_cmd.channels_present;
    assign cmd_word.left_sample      = i_cmd.left_sample;
    assign cmd_word.right_sample     = i_cmd.right_sample;

    acrf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (ctrl_cmd)
    );

    acrf_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (ctrl_cmd),
        .i_word     (cmd_word),
        .o_word     (rsp_word)
    );

    assign o_rsp.done_ok         = rsp_word.done_ok;
    assign o_rsp.phase_now       = rsp_word.phase_now;
    assign o_rsp.failure_code    = rsp_word.failure_code;
    assign o_rsp.frame_valid     = rsp_word.frame_valid;
    assign o_rsp.left_out        = rsp_word.left_out;
    assign o_rsp.right_out       = rsp_word.right_out;
    assign o_rsp.fill_level      = rsp_word.fill_level;
    assign o_rsp.frames_accepted = rsp_word.frames_accepted;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.fill_level <= CAP_W'(RING_DEPTH)))
        else $error("fill level above ring depth");

    a_frame_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.frame_valid) |-> o_rsp.done_ok)
        else $error("drained frame without done_ok");

    a_idle_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.phase_now == PH_IDLE)) |-> (o_rsp.frames_accepted == '0))
        else $error("nonzero frame count in idle");

    a_fail_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> ((o_rsp.failure_code != FAIL_NONE) == (o_rsp.phase_now == PH_FAILED)))
        else $error("failure code and failed phase disagree");
`endif

endmodule

@@ sv/acrf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO controller
// Sequences latch, execute and result load for each command word.
// ----------------------------------------------------------------------------
module acrf_ctrl import acrf_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;
    logic   accept;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_LOAD);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        o_cmd.latch = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                // result slot must be free before state is committed
                if (out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_LOAD;
                end
            end
            S_LOAD: begin
                o_cmd.load  = 1'b1;
                n_out_valid = 1'b1;
                n_state     = accept ? S_EXEC : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/acrf_datapath.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO datapath
// Lifecycle registers, ring pointers, sample memories and result register.
// ----------------------------------------------------------------------------
module acrf_datapath import acrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    input  t_ctrl_cmd        i_cmd,
    input  t_cmd             i_word,
    output t_rsp             o_word
);

    logic [SAMPLE_BITS-1:0] left_mem  [RING_DEPTH];
    logic [SAMPLE_BITS-1:0] right_mem [RING_DEPTH];

    t_cmd                   r_cmd;
    logic [CAP_W-1:0]       r_cap;
    logic [ADDR_W-1:0]      r_wslot, n_wslot;
    logic [ADDR_W-1:0]      r_rslot, n_rslot;
    logic [CAP_W-1:0]       r_held, n_held;
    logic [COUNT_W-1:0]     r_acc, n_acc;
    logic [2:0]             r_phase, n_phase;
    logic [1:0]             r_fail, n_fail;
    logic [SESSION_W-1:0]   r_session, n_session;
    logic                   r_stereo, n_stereo;
    logic [COUNT_W-1:0]     r_start, n_start;
    logic                   r_ok, n_ok;
    logic                   r_valid, n_valid;
    logic [SAMPLE_BITS-1:0] r_left_rd, r_right_rd;
    t_rsp                   r_rsp;

    logic [CAP_W-1:0]       eff_cap;
    logic [CAP_W-1:0]       wslot_inc, rslot_inc;
    logic                   active;
    logic                   prep_ok;
    logic                   missing;
    logic                   wr_en, rd_en;

    assign eff_cap   = (r_cap == '0) ? CAP_W'(1) :
                       (r_cap > CAP_W'(RING_DEPTH)) ? CAP_W'(RING_DEPTH) : r_cap;
    assign wslot_inc = {1'b0, r_wslot} + CAP_W'(1);
    assign rslot_inc = {1'b0, r_rslot} + CAP_W'(1);
    assign active    = (r_phase == PH_PREPARED) || (r_phase == PH_CAPTURING);
    assign prep_ok   = (r_cmd.session_id != '0) && !active;
    assign missing   = (r_cmd.channels_present == 2'd0) ||
                       (r_stereo && (r_cmd.channels_present == 2'd1));

    always_comb begin
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_held    = r_held;
        n_acc     = r_acc;
        n_phase   = r_phase;
        n_fail    = r_fail;
        n_session = r_session;
        n_stereo  = r_stereo;
        n_start   = r_start;
        n_ok      = 1'b0;
        n_valid   = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        case (r_cmd.mode)
            MODE_RESET: begin
                if (!active) begin
                    n_wslot   = '0;
                    n_rslot   = '0;
                    n_held    = '0;
                    n_acc     = '0;
                    n_session = '0;
                    n_start   = '0;
                    n_phase   = PH_IDLE;
                    n_fail    = FAIL_NONE;
                    n_ok      = 1'b1;
                end
            end
            MODE_PREPARE: begin
                if (prep_ok) begin
                    n_session = r_cmd.session_id;
                    n_stereo  = r_cmd.layout_stereo;
                    n_start   = '0;
                    n_phase   = PH_PREPARED;
                    n_fail    = FAIL_NONE;
                    n_ok      = 1'b1;
                end
            end
            MODE_CLEAR: begin
                if (r_phase == PH_PREPARED) begin
                    n_session = '0;
                    n_start   = '0;
                    n_phase   = PH_IDLE;
                    n_fail    = FAIL_NONE;
                    n_ok      = 1'b1;
                end
            end
            MODE_BEGIN: begin
                // auto-prepare from an inactive phase, else match the prepared request
                if (prep_ok || ((r_phase == PH_PREPARED) && (r_cmd.session_id != '0) &&
                    (r_session == r_cmd.session_id) &&
                    (r_stereo == r_cmd.layout_stereo))) begin
                    n_session = r_cmd.session_id;
                    n_stereo  = r_cmd.layout_stereo;
                    n_start   = r_cmd.start_frame;
                    n_wslot   = '0;
                    n_rslot   = '0;
                    n_held    = '0;
                    n_acc     = '0;
                    n_phase   = PH_CAPTURING;
                    n_fail    = FAIL_NONE;
                    n_ok      = 1'b1;
                end
            end
            MODE_CAPTURE: begin
                if (r_phase == PH_CAPTURING) begin
                    if (missing) begin
                        n_phase = PH_FAILED;
                        n_fail  = FAIL_MISSING;
                    end else if (r_held >= eff_cap) begin
                        n_phase = PH_FAILED;
                        n_fail  = FAIL_OVERFLOW;
                    end else begin
                        wr_en   = 1'b1;
                        n_wslot = (wslot_inc >= eff_cap) ? '0 : wslot_inc[ADDR_W-1:0];
                        n_held  = r_held + CAP_W'(1);
                        if (r_acc != '1) begin
                            n_acc = r_acc + COUNT_W'(1);
                        end
                        n_ok    = 1'b1;
                    end
                end
            end
            MODE_STOP: begin
                if ((r_phase == PH_CAPTURING) && (r_fail == FAIL_NONE)) begin
                    n_phase = PH_COMPLETE;
                    n_ok    = 1'b1;
                end
            end
            MODE_DRAIN: begin
                if ((r_phase != PH_IDLE) && (r_phase != PH_PREPARED) && (r_held != '0)) begin
                    rd_en   = 1'b1;
                    n_rslot = (rslot_inc >= eff_cap) ? '0 : rslot_inc[ADDR_W-1:0];
                    n_held  = r_held - CAP_W'(1);
                    n_valid = 1'b1;
                    n_ok    = 1'b1;
                end
            end
            MODE_STATUS: begin
                n_ok = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
        if (!i_cmd.exec) begin
            wr_en = 1'b0;
            rd_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_cmd <= i_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            left_mem[r_wslot] <= r_cmd.left_sample[SAMPLE_BITS-1:0];
            if (r_stereo) begin
                right_mem[r_wslot] <= r_cmd.right_sample[SAMPLE_BITS-1:0];
            end
        end
        if (rd_en) begin
            r_left_rd  <= left_mem[r_rslot];
            r_right_rd <= right_mem[r_rslot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap     <= CAP_W'(RING_DEPTH);
            r_wslot   <= '0;
            r_rslot   <= '0;
            r_held    <= '0;
            r_acc     <= '0;
            r_phase   <= PH_IDLE;
            r_fail    <= FAIL_NONE;
            r_session <= '0;
            r_stereo  <= 1'b0;
            r_start   <= '0;
            r_ok      <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.exec) begin
                r_wslot   <= n_wslot;
                r_rslot   <= n_rslot;
                r_held    <= n_held;
                r_acc     <= n_acc;
                r_phase   <= n_phase;
                r_fail    <= n_fail;
                r_session <= n_session;
                r_stereo  <= n_stereo;
                r_start   <= n_start;
                r_ok      <= n_ok;
                r_valid   <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rsp.done_ok         <= r_ok;
            r_rsp.phase_now       <= r_phase;
            r_rsp.failure_code    <= r_fail;
            r_rsp.frame_valid     <= r_valid;
            r_rsp.left_out        <= r_valid ? WORD_W'(r_left_rd) : '0;
            r_rsp.right_out       <= (r_valid && r_stereo) ? WORD_W'(r_right_rd) : '0;
            r_rsp.fill_level      <= r_held;
            r_rsp.frames_accepted <= (r_phase == PH_IDLE) ? '0 : r_acc;
        end
    end

    assign o_word = r_rsp;

endmodule

@@ tb/sv/audio_capture_ring_fifo_checker.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO checker
// Watches the command and result channels and the capacity write port, keeps
// its own copy of the ring, lifecycle and counts, predicts one result word per
// accepted command word and compares every accepted result word field by field.
// ----------------------------------------------------------------------------
module audio_capture_ring_fifo_checker import acrf_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_data,
    acrf_cmd_if              i_cmd,
    acrf_rsp_if              i_rsp,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WORD_W-1:0]    left_mem  [RING_DEPTH];
    logic [WORD_W-1:0]    right_mem [RING_DEPTH];
    int                   wr_slot;
    int                   rd_slot;
    int                   held;
    logic [COUNT_W-1:0]   accepted;
    logic [2:0]           ph_q;
    logic [1:0]           fail_q;
    logic [SESSION_W-1:0] session_q;
    logic                 stereo_q;
    logic [COUNT_W-1:0]   start_q;
    logic [CAP_W-1:0]     cap_q;
    t_rsp                 expected_rsp_q[$];
    int                   fail_cnt = 0;
    int                   check_cnt = 0;

    function automatic int eff_capacity();
        if (cap_q < 1) return 1;
        if (cap_q > RING_DEPTH) return RING_DEPTH;
        return int'(cap_q);
    endfunction

    function automatic int next_slot(input int s);
        return (s + 1 >= eff_capacity()) ? 0 : s + 1;
    endfunction

    function automatic bit is_active();
        return ph_q == PH_PREPARED || ph_q == PH_CAPTURING;
    endfunction

    function automatic bit try_prepare(input logic [SESSION_W-1:0] sid, input logic st);
        if (sid == '0 || is_active()) return 1'b0;
        session_q = sid;
        stereo_q  = st;
        start_q   = '0;
        ph_q      = PH_PREPARED;
        fail_q    = FAIL_NONE;
        return 1'b1;
    endfunction

    function automatic t_rsp predict_result(input t_cmd c);
        t_rsp r;
        bit   good;
        int   need;
        int   have;
        int   s;
        r = '0;
        case (c.mode)
            MODE_RESET: begin
                if (!is_active()) begin
                    wr_slot   = 0;
                    rd_slot   = 0;
                    held      = 0;
                    accepted  = '0;
                    session_q = '0;
                    start_q   = '0;
                    ph_q      = PH_IDLE;
                    fail_q    = FAIL_NONE;
                    r.done_ok = 1'b1;
                end
            end
            MODE_PREPARE: r.done_ok = try_prepare(c.session_id, c.layout_stereo);
            MODE_CLEAR: begin
                if (ph_q == PH_PREPARED) begin
                    ph_q      = PH_IDLE;
                    fail_q    = FAIL_NONE;
                    session_q = '0;
                    start_q   = '0;
                    r.done_ok = 1'b1;
                end
            end
            MODE_BEGIN: begin
                good = 1'b1;
                if (!is_active()) good = try_prepare(c.session_id, c.layout_stereo);
                if (good && c.session_id != '0 && ph_q == PH_PREPARED &&
                    session_q == c.session_id && stereo_q == c.layout_stereo) begin
                    start_q   = c.start_frame;
                    wr_slot   = 0;
                    rd_slot   = 0;
                    held      = 0;
                    accepted  = '0;
                    ph_q      = PH_CAPTURING;
                    fail_q    = FAIL_NONE;
                    r.done_ok = 1'b1;
                end
            end
            MODE_CAPTURE: begin
                if (ph_q == PH_CAPTURING) begin
                    need = stereo_q ? 2 : 1;
                    have = (c.channels_present > 2) ? 2 : int'(c.channels_present);
                    if (have < need) begin
                        ph_q   = PH_FAILED;
                        fail_q = FAIL_MISSING;
                    end else if (held >= eff_capacity()) begin
                        ph_q   = PH_FAILED;
                        fail_q = FAIL_OVERFLOW;
                    end else begin
                        s = wr_slot % RING_DEPTH;
                        left_mem[s] = c.left_sample;
                        if (stereo_q) right_mem[s] = c.right_sample;
                        wr_slot = next_slot(s);
                        held++;
                        if (accepted != '1) accepted++;
                        r.done_ok = 1'b1;
                    end
                end
            end
            MODE_STOP: begin
                if (ph_q == PH_CAPTURING && fail_q == FAIL_NONE) begin
                    ph_q      = PH_COMPLETE;
                    r.done_ok = 1'b1;
                end
            end
            MODE_DRAIN: begin
                if (ph_q != PH_IDLE && ph_q != PH_PREPARED && held > 0) begin
                    s = rd_slot % RING_DEPTH;
                    r.left_out    = left_mem[s];
                    r.right_out   = stereo_q ? right_mem[s] : '0;
                    rd_slot       = next_slot(s);
                    held--;
                    r.frame_valid = 1'b1;
                    r.done_ok     = 1'b1;
                end
            end
            default: r.done_ok = 1'b1;
        endcase
        r.phase_now       = ph_q;
        r.failure_code    = fail_q;
        r.fill_level      = CAP_W'(held);
        r.frames_accepted = (ph_q == PH_IDLE) ? '0 : accepted;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_cnt++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cmd c;
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            wr_slot   = 0;
            rd_slot   = 0;
            held      = 0;
            accepted  = '0;
            ph_q      = PH_IDLE;
            fail_q    = FAIL_NONE;
            session_q = '0;
            stereo_q  = 1'b0;
            start_q   = '0;
            cap_q     = CAP_W'(RING_DEPTH);
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) cap_q = i_cfg_data;
            if (i_cmd.valid && i_cmd.ready) begin
                c = '{i_cmd.mode, i_cmd.layout_stereo, i_cmd.session_id, i_cmd.start_frame,
                      i_cmd.channels_present, i_cmd.left_sample, i_cmd.right_sample};
                expected_rsp_q.push_back(predict_result(c));
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got = '{i_rsp.done_ok, i_rsp.phase_now, i_rsp.failure_code, i_rsp.frame_valid,
                        i_rsp.left_out, i_rsp.right_out, i_rsp.fill_level,
                        i_rsp.frames_accepted};
                if (expected_rsp_q.size() == 0) begin
                    $error("result word with no command word outstanding");
                    fail_cnt++;
                end else begin
                    want = expected_rsp_q.pop_front();
                    check_field("done_ok", want.done_ok, got.done_ok);
                    check_field("phase_now", want.phase_now, got.phase_now);
                    check_field("failure_code", want.failure_code, got.failure_code);
                    check_field("frame_valid", want.frame_valid, got.frame_valid);
                    check_field("left_out", want.left_out, got.left_out);
                    check_field("right_out", want.right_out, got.right_out);
                    check_field("fill_level", want.fill_level, got.fill_level);
                    check_field("frames_accepted", want.frames_accepted,
                                got.frames_accepted);
                    check_cnt++;
                end
            end
        end
        o_fail_count <= fail_cnt;
        o_pending    <= expected_rsp_q.size();
        o_checked    <= check_cnt;
    end

endmodule

@@ tb/sv/audio_capture_ring_fifo_tb.sv @@
// ----------------------------------------------------------------------------
// Audio capture ring FIFO testbench
// Drives directed and session-shaped random command words with random gaps on
// both channels, walks the ring capacity through several settings, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module audio_capture_ring_fifo_tb import acrf_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CAP_W-1:0] cfg_data;
    int               n_sent = 0;
    int               n_cfg = 0;
    int               fails;
    int               pending;
    int               checked;

    acrf_cmd_if cmd_ch ();
    acrf_rsp_if rsp_ch ();

    audio_capture_ring_fifo dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_ch),
        .o_rsp      (rsp_ch)
    );

    audio_capture_ring_fifo_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_cmd        (cmd_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic t_cmd rand_cmd(input logic [2:0] m);
        t_cmd c;
        c.mode             = m;
        c.layout_stereo    = 1'($urandom_range(0, 1));
        c.session_id       = 16'($urandom);
        c.start_frame      = {16'($urandom), 32'($urandom)};
        c.channels_present = 2'($urandom_range(0, 3));
        c.left_sample      = $urandom;
        c.right_sample     = $urandom;
        return c;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_cmd(input t_cmd c);
        int gap;
        gap = $urandom_range(0, 9);
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_ch.mode             <= c.mode;
        cmd_ch.layout_stereo    <= c.layout_stereo;
        cmd_ch.session_id       <= c.session_id;
        cmd_ch.start_frame      <= c.start_frame;
        cmd_ch.channels_present <= c.channels_present;
        cmd_ch.left_sample      <= c.left_sample;
        cmd_ch.right_sample     <= c.right_sample;
        cmd_ch.valid            <= 1'b1;
        do @(posedge clk); while (!cmd_ch.ready);
        @(negedge clk);
        n_sent++;
    endtask

    task automatic send_op(input logic [2:0] m, input logic st,
                           input logic [SESSION_W-1:0] sid, input logic [1:0] chans);
        t_cmd c;
        c = rand_cmd(m);
        c.layout_stereo    = st;
        c.session_id       = sid;
        c.channels_present = chans;
        send_cmd(c);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] value);
        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        n_cfg++;
    endtask

    task automatic run_session();
        t_cmd                 c;
        logic [SESSION_W-1:0] sid;
        logic                 lay;
        logic [1:0]           chans;
        sid = 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 3) == 0) sid = 16'($urandom_range(1, 3));
        lay = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 1) == 1) send_op(MODE_RESET, lay, sid, 2'd0);
        if ($urandom_range(0, 1) == 1) send_op(MODE_PREPARE, lay, sid, 2'd0);
        c = rand_cmd(MODE_BEGIN);
        c.session_id    = ($urandom_range(0, 15) == 0) ? sid ^ 16'd1 : sid;
        c.layout_stereo = ($urandom_range(0, 15) == 0) ? ~lay : lay;
        send_cmd(c);
        repeat ($urandom_range(1, 24)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    chans = lay ? 2'($urandom_range(2, 3)) : 2'($urandom_range(1, 3));
                    if ($urandom_range(0, 29) == 0) chans = lay ? 2'($urandom_range(0, 1)) : 2'd0;
                    send_op(MODE_CAPTURE, 1'($urandom_range(0, 1)), 16'($urandom), chans);
                end
                6, 7, 8: send_cmd(rand_cmd(MODE_DRAIN));
                default: send_cmd(rand_cmd(MODE_STATUS));
            endcase
        end
        if ($urandom_range(0, 4) != 0) send_cmd(rand_cmd(MODE_STOP));
        repeat ($urandom_range(0, 6)) send_cmd(rand_cmd(MODE_DRAIN));
    endtask

    initial begin
        t_cmd             c;
        logic [CAP_W-1:0] caps [8];
        int               target;
        int               rand_start;
        rst_n                   = 1'b0;
        cfg_we                  = 1'b0;
        cfg_data                = '0;
        cmd_ch.valid            = 1'b0;
        cmd_ch.mode             = MODE_STATUS;
        cmd_ch.layout_stereo    = 1'b0;
        cmd_ch.session_id       = '0;
        cmd_ch.start_frame      = '0;
        cmd_ch.channels_present = '0;
        cmd_ch.left_sample      = '0;
        cmd_ch.right_sample     = '0;
        caps = '{13'd1, 13'd64, 13'd2, 13'($urandom_range(3, 16)),
                 13'($urandom_range(1, 64)), 13'd5, 13'd1, 13'($urandom_range(17, 64))};
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        set_capacity(13'd4096);

        // directed: lifecycle edges, rejects and layout/session mismatches
        send_op(MODE_STATUS, 1'b0, 16'd0, 2'd0);
        send_op(MODE_DRAIN, 1'b0, 16'd0, 2'd0);
        send_op(MODE_CAPTURE, 1'b0, 16'd1, 2'd2);
        send_op(MODE_CLEAR, 1'b0, 16'd1, 2'd0);
        send_op(MODE_PREPARE, 1'b1, 16'd0, 2'd0);
        send_op(MODE_PREPARE, 1'b1, 16'hFFFF, 2'd0);
        send_op(MODE_PREPARE, 1'b0, 16'd5, 2'd0);
        send_op(MODE_RESET, 1'b0, 16'd0, 2'd0);
        send_op(MODE_CLEAR, 1'b0, 16'd0, 2'd0);
        send_op(MODE_BEGIN, 1'b0, 16'd0, 2'd0);
        c = rand_cmd(MODE_BEGIN);
        c.layout_stereo = 1'b0;
        c.session_id    = 16'd1;
        c.start_frame   = '1;
        send_cmd(c);
        c = rand_cmd(MODE_CAPTURE);
        c.channels_present = 2'd1;
        c.left_sample      = '1;
        c.right_sample     = '1;
        send_cmd(c);
        c = rand_cmd(MODE_CAPTURE);
        c.channels_present = 2'd3;
        c.left_sample      = '0;
        c.right_sample     = '0;
        send_cmd(c);
        send_op(MODE_DRAIN, 1'b0, 16'd0, 2'd0);
        send_op(MODE_DRAIN, 1'b0, 16'd0, 2'd0);
        send_op(MODE_DRAIN, 1'b0, 16'd0, 2'd0);
        send_op(MODE_STOP, 1'b0, 16'd0, 2'd0);
        send_op(MODE_STOP, 1'b0, 16'd0, 2'd0);
        send_op(MODE_CAPTURE, 1'b0, 16'd1, 2'd2);
        c = rand_cmd(MODE_BEGIN);
        c.layout_stereo = 1'b1;
        c.session_id    = 16'hFFFF;
        c.start_frame   = '0;
        send_cmd(c);
        send_op(MODE_CAPTURE, 1'b1, 16'd0, 2'd1);
        send_op(MODE_STOP, 1'b0, 16'd0, 2'd0);
        send_op(MODE_RESET, 1'b0, 16'd0, 2'd0);
        send_op(MODE_PREPARE, 1'b1, 16'd5, 2'd0);
        send_op(MODE_BEGIN, 1'b1, 16'd6, 2'd0);
        send_op(MODE_BEGIN, 1'b0, 16'd5, 2'd0);
        send_op(MODE_BEGIN, 1'b1, 16'd5, 2'd2);

        // fill a 64-frame ring in stereo, then overflow it; later capacities
        // stay within these entries
        set_capacity(13'd64);
        send_op(MODE_RESET, 1'b0, 16'd0, 2'd0);
        send_op(MODE_BEGIN, 1'b1, 16'($urandom_range(1, 65535)), 2'd0);
        for (int i = 0; i < 65; i++) begin
            send_op(MODE_CAPTURE, 1'($urandom_range(0, 1)), 16'($urandom),
                    2'($urandom_range(2, 3)));
        end
        repeat (3) send_cmd(rand_cmd(MODE_DRAIN));

        // random sessions over several capacities; frames may still be held
        rand_start = n_sent;
        for (int p = 0; p < 8; p++) begin
            set_capacity(caps[p]);
            repeat ($urandom_range(1, 4)) send_cmd(rand_cmd(MODE_DRAIN));
            send_op(MODE_CAPTURE, 1'b0, 16'd0, 2'd2);
            target = rand_start + (p + 1) * 85;
            while (n_sent < target) begin
                if ($urandom_range(0, 4) != 0) begin
                    run_session();
                end else begin
                    repeat ($urandom_range(1, 5)) send_cmd(rand_cmd(3'($urandom_range(0, 7))));
                end
            end
        end

        cmd_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        $display("Summary: %0d command words over %0d capacity settings, %0d results checked",
                 n_sent, n_cfg, checked);
        if (fails == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        int stall;
        rsp_ch.ready = 1'b0;
        @(negedge clk);
        forever begin
            stall = $urandom_range(0, 9);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge clk); while (!rsp_ch.valid);
            @(negedge clk);
        end
    end

endmodule
